>>> rtl/dnsmsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser package
// Beat types, status codes and result queue sizing shared by the parser
// top level and its result queue.
// ----------------------------------------------------------------------------
package dnsmsp_pkg;

   // Status codes of a message status result.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd2;
   localparam logic [2:0] STATUS_TRAILING  = 3'd3;
   localparam logic [2:0] STATUS_OVERSIZE  = 3'd4;

   // Result kinds.
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Header length and fixed field lengths in bytes.
   localparam logic [9:0] HEADER_BYTES     = 10'd12;
   localparam logic [3:0] QUESTION_FIXED   = 4'd4;
   localparam logic [3:0] RESOURCE_FIXED   = 4'd10;
   localparam logic [3:0] SHIFT_BYTES      = 4'd8;

   // Result queue: one entry per input beat that has results, two entries deep.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic        kind;
      logic [1:0]  section;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] time_to_live;
      logic [9:0]  name_length;
      logic [8:0]  data_offset;
      logic [15:0] data_length;
      logic [15:0] message_id;
      logic [15:0] header_flags;
      logic [2:0]  status;
   } rsp_type;

   // Everything one input beat produces: a record result, a status result,
   // or both in that order.
   typedef struct packed {
      logic    rec_valid;
      rsp_type rec;
      logic    stat_valid;
      rsp_type stat;
   } pair_type;

endpackage

>>> rtl/dnsmsp_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message parser result queue
// Holds the results of recent input beats and hands them out one result
// beat at a time, record result first and status result second.
// ----------------------------------------------------------------------------
module dnsmsp_rsp_queue
   import dnsmsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   output logic     full,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam logic [QUEUE_AW:0] DepthCount = (QUEUE_AW + 1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW:0] CountOne   = (QUEUE_AW + 1)'(1);

   pair_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    half_ff, half_in;
   pair_type                head;
   logic                    show_rec;
   logic                    pop_beat;
   logic                    pop_entry;

   assign full = (count_ff == DepthCount);

   // The head entry shows its record result first, then its status result.
   assign head      = entry_ff[rd_ptr_ff];
   assign show_rec  = head.rec_valid && !half_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = show_rec ? head.rec : head.stat;
   assign pop_beat  = rsp_valid && !rsp_stall;
   assign pop_entry = pop_beat && (!show_rec || !head.stat_valid);

   // Pointer, fill count and half-entry bookkeeping.
   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_entry ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_entry) begin
         count_in = count_ff + CountOne;
      end else if (!push && pop_entry) begin
         count_in = count_ff - CountOne;
      end
      half_in = half_ff;
      if (pop_entry) begin
         half_in = 1'b0;
      end else if (pop_beat) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/dns_message_section_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS message section parser
// Walks the header, questions and resource records of a DNS message fed one
// byte per beat and reports each record and a final message status.
// ----------------------------------------------------------------------------
// The parser takes one message byte per clock cycle. Each byte is parsed in
// the cycle it is accepted and updates a few counters and field registers;
// its results (a record result when a record's fixed fields complete, and a
// status result after the byte marked last) enter a two-entry result queue
// and reach the result channel behind earlier results. A byte that causes
// two results needs two result beats, so input stalls only when the result
// queue is full, which happens when the result side is stalled or when
// records and message ends come in quick succession. Sustained rate is one
// byte per cycle while the queue is not full. The user must write the length
// limit register only while no message is in flight; it is not enforced.
module dns_message_section_parser
   import dnsmsp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 512
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [9:0] csr_write_data
);

   localparam logic [10:0] MaxBytes = 11'(MAX_MESSAGE_BYTES);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_FIXED,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [1:0]  section;
      logic [15:0] remaining;
      logic        found;
   } seek_type;

   // Count of one section from the packed header counts.
   function automatic logic [15:0] count_of(input logic [63:0] counts,
                                            input logic [1:0]  sec);
      logic [15:0] c;
      case (sec)
         2'd0:    c = counts[63:48];
         2'd1:    c = counts[47:32];
         2'd2:    c = counts[31:16];
         default: c = counts[15:0];
      endcase
      return c;
   endfunction

   // Skip past sections with nothing left to find the next record.
   function automatic seek_type seek(input logic [63:0] counts,
                                     input logic [1:0]  sec,
                                     input logic [15:0] rem);
      seek_type r;
      r.section   = sec;
      r.remaining = rem;
      for (int i = 0; i < 3; i++) begin
         if (r.remaining == 16'd0 && r.section != 2'd3) begin
            r.section   = r.section + 2'd1;
            r.remaining = count_of(counts, r.section);
         end
      end
      r.found = (r.remaining != 16'd0);
      return r;
   endfunction

   logic [9:0]  max_length_ff;
   logic [9:0]  byte_pos_ff,   byte_pos_in;
   phase_type   phase_ff,      phase_in;
   logic [3:0]  field_cnt_ff,  field_cnt_in;
   logic [31:0] id_flags_ff,   id_flags_in;
   logic [63:0] counts_ff,     counts_in;
   logic [1:0]  section_ff,    section_in;
   logic [15:0] remaining_ff,  remaining_in;
   logic [9:0]  name_len_ff,   name_len_in;
   logic [63:0] shift_ff,      shift_in;
   logic [15:0] data_left_ff,  data_left_in;
   logic [2:0]  error_ff,      error_in;

   logic [10:0] limit;
   logic        accept;
   logic        full;
   logic [7:0]  b;
   logic        question;
   logic [3:0]  need;
   logic [15:0] rem_dec;
   logic [15:0] data_dec;
   seek_type    sk;
   pair_type    pair;
   logic [2:0]  status_code;

   assign limit     = ({1'b0, max_length_ff} < MaxBytes) ? {1'b0, max_length_ff} : MaxBytes;
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.data_byte;
   assign question  = (section_ff == 2'd0);
   assign need      = question ? QUESTION_FIXED : RESOURCE_FIXED;
   assign rem_dec   = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : 16'd0;
   assign data_dec  = (data_left_ff != 16'd0) ? data_left_ff - 16'd1 : 16'd0;

   // Parse one byte: next state and the results it causes.
   always_comb begin
      byte_pos_in  = byte_pos_ff;
      phase_in     = phase_ff;
      field_cnt_in = field_cnt_ff;
      id_flags_in  = id_flags_ff;
      counts_in    = counts_ff;
      section_in   = section_ff;
      remaining_in = remaining_ff;
      name_len_in  = name_len_ff;
      shift_in     = shift_ff;
      data_left_in = data_left_ff;
      error_in     = error_ff;
      sk           = '0;
      pair         = '0;
      status_code  = STATUS_OK;

      if (error_ff == STATUS_OVERSIZE || {1'b0, byte_pos_ff} >= limit) begin
         error_in = STATUS_OVERSIZE;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (byte_pos_ff < 10'd4) begin
                  id_flags_in = {id_flags_ff[23:0], b};
               end else begin
                  counts_in = {counts_ff[55:0], b};
               end
               if (byte_pos_ff >= HEADER_BYTES - 10'd1) begin
                  sk           = seek(counts_in, 2'd0, counts_in[63:48]);
                  section_in   = sk.section;
                  remaining_in = sk.remaining;
                  phase_in     = sk.found ? PH_NAME : PH_DONE;
                  if (sk.found) begin
                     name_len_in = '0;
                  end
               end
            end
            PH_NAME: begin
               if (name_len_ff != 10'h3FF) begin
                  name_len_in = name_len_ff + 10'd1;
               end
               if (b == 8'd0) begin
                  phase_in     = PH_FIXED;
                  field_cnt_in = '0;
                  shift_in     = '0;
                  data_left_in = '0;
               end
            end
            PH_FIXED: begin
               if (field_cnt_ff < SHIFT_BYTES) begin
                  shift_in = {shift_ff[55:0], b};
               end else begin
                  data_left_in = {data_left_ff[7:0], b};
               end
               field_cnt_in = field_cnt_ff + 4'd1;
               if (field_cnt_in >= need) begin
                  // The record's fixed fields are complete.
                  pair.rec_valid       = 1'b1;
                  pair.rec.kind        = KIND_RECORD;
                  pair.rec.section     = section_ff;
                  pair.rec.name_length = name_len_ff;
                  pair.rec.data_offset = 9'(byte_pos_ff + 10'd1);
                  if (question) begin
                     pair.rec.record_type  = shift_in[31:16];
                     pair.rec.record_class = shift_in[15:0];
                  end else begin
                     pair.rec.record_type  = shift_in[63:48];
                     pair.rec.record_class = shift_in[47:32];
                     pair.rec.time_to_live = shift_in[31:0];
                     pair.rec.data_length  = data_left_in;
                  end
                  field_cnt_in = '0;
                  if (!question && data_left_in != 16'd0) begin
                     phase_in = PH_DATA;
                  end else begin
                     sk           = seek(counts_ff, section_ff, rem_dec);
                     section_in   = sk.section;
                     remaining_in = sk.remaining;
                     phase_in     = sk.found ? PH_NAME : PH_DONE;
                     if (sk.found) begin
                        name_len_in = '0;
                     end
                  end
               end
            end
            PH_DATA: begin
               data_left_in = data_dec;
               if (data_dec == 16'd0) begin
                  sk           = seek(counts_ff, section_ff, rem_dec);
                  section_in   = sk.section;
                  remaining_in = sk.remaining;
                  phase_in     = sk.found ? PH_NAME : PH_DONE;
                  if (sk.found) begin
                     name_len_in = '0;
                  end
               end
            end
            PH_DONE: begin
               error_in = STATUS_TRAILING;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      if (byte_pos_ff != 10'h3FF) begin
         byte_pos_in = byte_pos_ff + 10'd1;
      end

      // The last byte closes the message with a status result.
      if (req_data.last_byte) begin
         if (error_in == STATUS_OVERSIZE) begin
            status_code = STATUS_OVERSIZE;
         end else if (byte_pos_in < HEADER_BYTES) begin
            status_code = STATUS_SHORT;
         end else if (phase_in != PH_DONE) begin
            status_code = STATUS_TRUNCATED;
         end else if (error_in == STATUS_TRAILING) begin
            status_code = STATUS_TRAILING;
         end else begin
            status_code = STATUS_OK;
         end
         pair.stat_valid        = 1'b1;
         pair.stat.kind         = KIND_STATUS;
         pair.stat.message_id   = id_flags_in[31:16];
         pair.stat.header_flags = id_flags_in[15:0];
         pair.stat.status       = status_code;

         byte_pos_in  = '0;
         phase_in     = PH_HEADER;
         field_cnt_in = '0;
         id_flags_in  = '0;
         counts_in    = '0;
         section_in   = '0;
         remaining_in = '0;
         name_len_in  = '0;
         shift_in     = '0;
         data_left_in = '0;
         error_in     = STATUS_OK;
      end
   end

   // Parse state, advanced on each accepted input beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         phase_ff     <= PH_HEADER;
         field_cnt_ff <= '0;
         id_flags_ff  <= '0;
         counts_ff    <= '0;
         section_ff   <= '0;
         remaining_ff <= '0;
         name_len_ff  <= '0;
         shift_ff     <= '0;
         data_left_ff <= '0;
         error_ff     <= STATUS_OK;
      end else if (accept) begin
         byte_pos_ff  <= byte_pos_in;
         phase_ff     <= phase_in;
         field_cnt_ff <= field_cnt_in;
         id_flags_ff  <= id_flags_in;
         counts_ff    <= counts_in;
         section_ff   <= section_in;
         remaining_ff <= remaining_in;
         name_len_ff  <= name_len_in;
         shift_ff     <= shift_in;
         data_left_ff <= data_left_in;
         error_ff     <= error_in;
      end
   end

   // Length limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= 10'd512;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   // Results wait here until the result side takes them.
   dnsmsp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && (pair.rec_valid || pair.stat_valid)),
      .push_data (pair),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
